// ===== hdl/ffa_pkg.sv =====
// shared constants, codes and types of the first-fit allocator
package ffa_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int QUEUE_DEPTH = 16;
  localparam int REQ_BITS    = 16;

  localparam int TIDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TCNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W = 16;
  localparam int LEN_W  = 17;
  localparam int OWN_W  = 16;
  localparam int VAL_W  = 17;
  localparam int CUR_W  = 18;

  localparam logic [LEN_W-1:0] MEM_MAX = 17'h10000;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_TERM  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LATCH,
    CMD_ADV,
    CMD_PLACE,
    CMD_REJECT,
    CMD_ENQ,
    CMD_JNEXT,
    CMD_JINC,
    CMD_STATUS,
    CMD_NEXT,
    CMD_TQ,
    CMD_TR,
    CMD_FIN
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FIT,
    ST_FREE_SCAN,
    ST_FREE_NEXT,
    ST_FREE_Q,
    ST_TERM_Q,
    ST_TERM_R,
    ST_STATUS,
    ST_RETRY,
    ST_FIN
  } state_e;

  typedef struct packed {
    op_e  op;
    logic cnt_zero;
    logic tbl_full;
    logic i_end;
    logic j_end;
    logic gap_ok;
    logic tail_ok;
    logic too_big;
    logic addr_eq;
    logic room_pos;
    logic wfit;
    logic gen_ok;
    logic out_free;
    logic hit;
    logic removed;
  } dp_status_t;

endpackage

// ===== hdl/ffa_dp.sv =====
// datapath: region table, waiting queue, walk pointers and result registers
module ffa_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ffa_pkg::cmd_e                  cmd_i,
  output ffa_pkg::dp_status_t            status_o,
  input  logic [1:0]                     in_op_i,
  input  logic [ffa_pkg::OWN_W-1:0]      in_owner_i,
  input  logic [ffa_pkg::LEN_W-1:0]      in_size_i,
  input  logic [ffa_pkg::ADDR_W-1:0]     in_addr_i,
  input  logic                           cfg_we_i,
  input  logic [ffa_pkg::LEN_W-1:0]      cfg_wdata_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [ffa_pkg::REQ_BITS-1:0]   out_num_o,
  output logic                           out_kind_o,
  output logic [ffa_pkg::VAL_W-1:0]      out_val_o,
  output logic                           out_ovf_o,
  output logic                           out_last_o
);

  logic [ffa_pkg::ADDR_W-1:0]   rstart_q [ffa_pkg::TABLE_DEPTH];
  logic [ffa_pkg::LEN_W-1:0]    rlen_q   [ffa_pkg::TABLE_DEPTH];
  logic [ffa_pkg::OWN_W-1:0]    rown_q   [ffa_pkg::TABLE_DEPTH];
  logic [ffa_pkg::TCNT_W-1:0]   rcnt_q;
  logic [ffa_pkg::LEN_W-1:0]    wlen_q   [ffa_pkg::QUEUE_DEPTH];
  logic [ffa_pkg::OWN_W-1:0]    wown_q   [ffa_pkg::QUEUE_DEPTH];
  logic [ffa_pkg::REQ_BITS-1:0] wreq_q   [ffa_pkg::QUEUE_DEPTH];
  logic [ffa_pkg::QCNT_W-1:0]   wcnt_q;

  logic [ffa_pkg::REQ_BITS-1:0] ctr_q, num_q;
  logic [ffa_pkg::LEN_W-1:0]    msize_q, size_q, next_q;
  ffa_pkg::op_e                 op_q;
  logic [ffa_pkg::OWN_W-1:0]    owner_q;
  logic [ffa_pkg::ADDR_W-1:0]   addr_q;
  logic [ffa_pkg::TCNT_W-1:0]   i_q;
  logic [ffa_pkg::QCNT_W-1:0]   j_q;
  logic [ffa_pkg::CUR_W-1:0]    cursor_q;
  logic                         removed_q;

  logic                         pend_v_q, pend_kind_q, pend_ovf_q;
  logic [ffa_pkg::REQ_BITS-1:0] pend_num_q;
  logic [ffa_pkg::VAL_W-1:0]    pend_val_q;
  logic                         out_v_q, out_kind_q, out_ovf_q, out_last_q;
  logic [ffa_pkg::REQ_BITS-1:0] out_num_q;
  logic [ffa_pkg::VAL_W-1:0]    out_val_q;

  logic [ffa_pkg::TIDX_W-1:0]   ii;
  logic [ffa_pkg::QIDX_W-1:0]   jj;
  logic [ffa_pkg::ADDR_W-1:0]   r_start;
  logic [ffa_pkg::LEN_W-1:0]    r_len, w_len, len_sel;
  logic [ffa_pkg::OWN_W-1:0]    r_own, w_own, own_sel;
  logic [ffa_pkg::REQ_BITS-1:0] w_req, num_sel;
  logic                         from_q, q_full, i_end, hit;
  logic [ffa_pkg::CUR_W:0]      cur_plus, cur_wplus;
  logic [ffa_pkg::CUR_W-1:0]    r_end;
  logic                         ins_en, rrem_en, qrem_en, enq_en;
  logic                         gen, push, out_free;
  logic [ffa_pkg::REQ_BITS-1:0] g_num;
  logic                         g_kind, g_ovf;
  logic [ffa_pkg::VAL_W-1:0]    g_val;

  assign ii      = i_q[ffa_pkg::TIDX_W-1:0];
  assign jj      = j_q[ffa_pkg::QIDX_W-1:0];
  assign r_start = rstart_q[ii];
  assign r_len   = rlen_q[ii];
  assign r_own   = rown_q[ii];
  assign w_len   = wlen_q[jj];
  assign w_own   = wown_q[jj];
  assign w_req   = wreq_q[jj];

  assign from_q  = (op_q != ffa_pkg::OP_ALLOC);
  assign len_sel = from_q ? w_len : size_q;
  assign own_sel = from_q ? w_own : owner_q;
  assign num_sel = from_q ? w_req : num_q;

  assign cur_plus  = {1'b0, cursor_q} + (ffa_pkg::CUR_W+1)'(len_sel);
  assign cur_wplus = {1'b0, cursor_q} + (ffa_pkg::CUR_W+1)'(w_len);
  assign r_end     = ffa_pkg::CUR_W'(r_start) + ffa_pkg::CUR_W'(r_len);
  assign q_full    = (wcnt_q >= ffa_pkg::QCNT_W'(ffa_pkg::QUEUE_DEPTH));
  assign i_end     = (i_q >= rcnt_q);
  assign hit       = !i_end && (r_start == addr_q) && (r_own == owner_q);
  assign out_free  = !out_v_q || out_ready_i;

  always_comb begin
    status_o.op       = op_q;
    status_o.cnt_zero = (rcnt_q == '0);
    status_o.tbl_full = (rcnt_q >= ffa_pkg::TCNT_W'(ffa_pkg::TABLE_DEPTH));
    status_o.i_end    = i_end;
    status_o.j_end    = (j_q >= wcnt_q);
    status_o.gap_ok   = ((ffa_pkg::CUR_W+1)'(r_start) >= cur_plus);
    status_o.tail_ok  = (cur_plus <= (ffa_pkg::CUR_W+1)'(msize_q)) &&
                        (cursor_q < ffa_pkg::CUR_W'(ffa_pkg::MEM_MAX));
    status_o.too_big  = (msize_q < size_q);
    status_o.addr_eq  = (r_start == addr_q);
    status_o.room_pos = (ffa_pkg::CUR_W'(next_q) > cursor_q);
    status_o.wfit     = (cur_wplus <= (ffa_pkg::CUR_W+1)'(next_q));
    status_o.gen_ok   = !pend_v_q || out_free;
    status_o.out_free = out_free;
    status_o.hit      = hit;
    status_o.removed  = removed_q;
  end

  always_comb begin
    ins_en  = (cmd_i == ffa_pkg::CMD_PLACE);
    qrem_en = ((cmd_i == ffa_pkg::CMD_PLACE) && from_q) ||
              ((cmd_i == ffa_pkg::CMD_TQ) && (w_own == owner_q));
    rrem_en = ((cmd_i == ffa_pkg::CMD_STATUS) && (op_q == ffa_pkg::OP_FREE) && hit) ||
              ((cmd_i == ffa_pkg::CMD_TR) && (r_own == owner_q));
    enq_en  = (cmd_i == ffa_pkg::CMD_ENQ) && !q_full;
    gen     = 1'b1;
    g_num   = num_q;
    g_kind  = 1'b0;
    g_val   = {ffa_pkg::VAL_W{1'b1}};
    g_ovf   = 1'b0;
    case (cmd_i)
      ffa_pkg::CMD_PLACE: begin
        g_num = num_sel;
        g_val = ffa_pkg::VAL_W'(cursor_q[ffa_pkg::ADDR_W-1:0]);
      end
      ffa_pkg::CMD_REJECT: ;
      ffa_pkg::CMD_ENQ: g_ovf = q_full;
      ffa_pkg::CMD_STATUS: begin
        g_kind = 1'b1;
        if (op_q == ffa_pkg::OP_FREE) begin
          g_val = hit ? ffa_pkg::VAL_W'(0) : ffa_pkg::VAL_W'(1);
        end else if (op_q == ffa_pkg::OP_TERM) begin
          g_val = removed_q ? ffa_pkg::VAL_W'(0) : ffa_pkg::VAL_W'(1);
        end else begin
          g_val = ffa_pkg::VAL_W'(1);
        end
      end
      default: gen = 1'b0;
    endcase
    push = (gen && pend_v_q) || (cmd_i == ffa_pkg::CMD_FIN);
  end

  // control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q    <= '0;
      wcnt_q    <= '0;
      ctr_q     <= '0;
      msize_q   <= ffa_pkg::MEM_MAX;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      cursor_q  <= '0;
      removed_q <= 1'b0;
      op_q      <= ffa_pkg::OP_ALLOC;
    end else begin
      if (cfg_we_i) begin
        msize_q <= (cfg_wdata_i > ffa_pkg::MEM_MAX) ? ffa_pkg::MEM_MAX : cfg_wdata_i;
      end
      if (push) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (gen) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i == ffa_pkg::CMD_FIN) begin
        pend_v_q <= 1'b0;
      end
      rcnt_q <= rcnt_q + ffa_pkg::TCNT_W'(ins_en) - ffa_pkg::TCNT_W'(rrem_en);
      wcnt_q <= wcnt_q + ffa_pkg::QCNT_W'(enq_en) - ffa_pkg::QCNT_W'(qrem_en);
      case (cmd_i)
        ffa_pkg::CMD_LATCH: begin
          op_q      <= ffa_pkg::op_e'(in_op_i);
          ctr_q     <= ctr_q + 1'b1;
          i_q       <= '0;
          j_q       <= '0;
          cursor_q  <= '0;
          removed_q <= 1'b0;
        end
        ffa_pkg::CMD_ADV: begin
          cursor_q <= r_end;
          i_q      <= i_q + 1'b1;
        end
        ffa_pkg::CMD_PLACE: begin
          if (op_q == ffa_pkg::OP_FREE) begin
            i_q      <= i_q + 1'b1;
            cursor_q <= cur_plus[ffa_pkg::CUR_W-1:0];
          end else begin
            i_q      <= '0;
            cursor_q <= '0;
          end
        end
        ffa_pkg::CMD_JNEXT: begin
          j_q      <= j_q + 1'b1;
          i_q      <= '0;
          cursor_q <= '0;
        end
        ffa_pkg::CMD_JINC: j_q <= j_q + 1'b1;
        ffa_pkg::CMD_STATUS: begin
          if (op_q == ffa_pkg::OP_TERM) begin
            i_q      <= '0;
            j_q      <= '0;
            cursor_q <= '0;
          end
        end
        ffa_pkg::CMD_TQ: begin
          if (w_own != owner_q) begin
            j_q <= j_q + 1'b1;
          end
        end
        ffa_pkg::CMD_TR: begin
          if (r_own == owner_q) begin
            removed_q <= 1'b1;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i == ffa_pkg::CMD_LATCH) begin
      owner_q <= in_owner_i;
      size_q  <= in_size_i;
      addr_q  <= in_addr_i;
      num_q   <= ctr_q;
    end
    if (cmd_i == ffa_pkg::CMD_NEXT) begin
      next_q <= i_end ? msize_q : ffa_pkg::LEN_W'(r_start);
    end
    if (gen) begin
      pend_num_q  <= g_num;
      pend_kind_q <= g_kind;
      pend_val_q  <= g_val;
      pend_ovf_q  <= g_ovf;
    end
    if (push) begin
      out_num_q  <= pend_num_q;
      out_kind_q <= pend_kind_q;
      out_val_q  <= pend_val_q;
      out_ovf_q  <= pend_ovf_q;
      out_last_q <= (cmd_i == ffa_pkg::CMD_FIN);
    end
  end

  // table: insert at the walk pointer or close the hole there
  always_ff @(posedge clk_i) begin
    if (ins_en) begin
      for (int k = 1; k < ffa_pkg::TABLE_DEPTH; k++) begin
        if (ffa_pkg::TIDX_W'(k) > ii) begin
          rstart_q[k] <= rstart_q[k-1];
          rlen_q[k]   <= rlen_q[k-1];
          rown_q[k]   <= rown_q[k-1];
        end
      end
      rstart_q[ii] <= cursor_q[ffa_pkg::ADDR_W-1:0];
      rlen_q[ii]   <= len_sel;
      rown_q[ii]   <= own_sel;
    end else if (rrem_en) begin
      for (int k = 0; k < ffa_pkg::TABLE_DEPTH - 1; k++) begin
        if (ffa_pkg::TIDX_W'(k) >= ii) begin
          rstart_q[k] <= rstart_q[k+1];
          rlen_q[k]   <= rlen_q[k+1];
          rown_q[k]   <= rown_q[k+1];
        end
      end
    end
  end

  // queue: append at the tail or close the hole at the queue pointer
  always_ff @(posedge clk_i) begin
    if (enq_en) begin
      wlen_q[wcnt_q[ffa_pkg::QIDX_W-1:0]] <= size_q;
      wown_q[wcnt_q[ffa_pkg::QIDX_W-1:0]] <= owner_q;
      wreq_q[wcnt_q[ffa_pkg::QIDX_W-1:0]] <= num_q;
    end else if (qrem_en) begin
      for (int k = 0; k < ffa_pkg::QUEUE_DEPTH - 1; k++) begin
        if (ffa_pkg::QIDX_W'(k) >= jj) begin
          wlen_q[k] <= wlen_q[k+1];
          wown_q[k] <= wown_q[k+1];
          wreq_q[k] <= wreq_q[k+1];
        end
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_num_o   = out_num_q;
  assign out_kind_o  = out_kind_q;
  assign out_val_o   = out_val_q;
  assign out_ovf_o   = out_ovf_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hdl/ffa_ctrl.sv =====
// controller: sequences the table and queue walks of one request
module ffa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ffa_pkg::dp_status_t status_i,
  output ffa_pkg::cmd_e       cmd_o
);

  ffa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = ffa_pkg::CMD_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      ffa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = ffa_pkg::CMD_LATCH;
          state_d = ffa_pkg::ST_DISPATCH;
        end
      end
      ffa_pkg::ST_DISPATCH: begin
        unique case (status_i.op)
          ffa_pkg::OP_ALLOC: begin
            if (status_i.cnt_zero && status_i.too_big) begin
              if (status_i.gen_ok) begin
                cmd_o   = ffa_pkg::CMD_REJECT;
                state_d = ffa_pkg::ST_FIN;
              end
            end else begin
              state_d = ffa_pkg::ST_FIT;
            end
          end
          ffa_pkg::OP_FREE: state_d = ffa_pkg::ST_FREE_SCAN;
          ffa_pkg::OP_TERM: state_d = ffa_pkg::ST_TERM_Q;
          default:          state_d = ffa_pkg::ST_STATUS;
        endcase
      end
      ffa_pkg::ST_FIT: begin
        if (!status_i.tbl_full && !status_i.i_end && !status_i.gap_ok) begin
          cmd_o = ffa_pkg::CMD_ADV;
        end else if (!status_i.tbl_full &&
                     (status_i.i_end ? status_i.tail_ok : status_i.gap_ok)) begin
          if (status_i.gen_ok) begin
            cmd_o   = ffa_pkg::CMD_PLACE;
            state_d = (status_i.op == ffa_pkg::OP_ALLOC) ? ffa_pkg::ST_FIN
                                                         : ffa_pkg::ST_RETRY;
          end
        end else if (status_i.op == ffa_pkg::OP_ALLOC) begin
          if (status_i.gen_ok) begin
            cmd_o   = ffa_pkg::CMD_ENQ;
            state_d = ffa_pkg::ST_FIN;
          end
        end else begin
          cmd_o   = ffa_pkg::CMD_JNEXT;
          state_d = ffa_pkg::ST_RETRY;
        end
      end
      ffa_pkg::ST_RETRY: begin
        state_d = status_i.j_end ? ffa_pkg::ST_FIN : ffa_pkg::ST_FIT;
      end
      ffa_pkg::ST_FREE_SCAN: begin
        if (status_i.i_end || status_i.addr_eq) begin
          state_d = ffa_pkg::ST_STATUS;
        end else begin
          cmd_o = ffa_pkg::CMD_ADV;
        end
      end
      ffa_pkg::ST_STATUS: begin
        if (status_i.gen_ok) begin
          cmd_o = ffa_pkg::CMD_STATUS;
          if ((status_i.op == ffa_pkg::OP_FREE) && status_i.hit) begin
            state_d = ffa_pkg::ST_FREE_NEXT;
          end else if ((status_i.op == ffa_pkg::OP_TERM) && status_i.removed) begin
            state_d = ffa_pkg::ST_RETRY;
          end else begin
            state_d = ffa_pkg::ST_FIN;
          end
        end
      end
      ffa_pkg::ST_FREE_NEXT: begin
        cmd_o   = ffa_pkg::CMD_NEXT;
        state_d = ffa_pkg::ST_FREE_Q;
      end
      ffa_pkg::ST_FREE_Q: begin
        if (status_i.j_end || !status_i.room_pos) begin
          state_d = ffa_pkg::ST_FIN;
        end else if (status_i.wfit && !status_i.tbl_full) begin
          if (status_i.gen_ok) begin
            cmd_o = ffa_pkg::CMD_PLACE;
          end
        end else begin
          cmd_o = ffa_pkg::CMD_JINC;
        end
      end
      ffa_pkg::ST_TERM_Q: begin
        if (status_i.j_end) begin
          state_d = ffa_pkg::ST_TERM_R;
        end else begin
          cmd_o = ffa_pkg::CMD_TQ;
        end
      end
      ffa_pkg::ST_TERM_R: begin
        if (status_i.i_end) begin
          state_d = ffa_pkg::ST_STATUS;
        end else begin
          cmd_o = ffa_pkg::CMD_TR;
        end
      end
      ffa_pkg::ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o   = ffa_pkg::CMD_FIN;
          state_d = ffa_pkg::ST_IDLE;
        end
      end
      default: state_d = ffa_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/first_fit_allocator_with_pending_queue_top.sv =====
// top level of the first-fit allocator with a queue of waiting requests
// one request at a time; allocate, free and terminate walk the region table and
//   waiting queue one entry per cycle, pausing while a result waits for the output register
// results leave through an output register; the next request is taken while one waits
// reset clears counts, request counter and flags, memory size returns to 65536;
//   table and queue contents stay unset, no clearing pass
module first_fit_allocator_with_pending_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // owner_id[15:0], request_size[32:16], free_address[48:33]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // request_number[15:0], answer_value[32:16], queue_overflow[33]
  output logic        m_axis_tuser,  // answer_kind[0]
  output logic        m_axis_tlast,
  // memory size register
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i
);

  ffa_pkg::cmd_e       cmd;
  ffa_pkg::dp_status_t status;

  logic [ffa_pkg::REQ_BITS-1:0] out_num;
  logic [ffa_pkg::VAL_W-1:0]    out_val;
  logic                         out_ovf;

  // sequencer: one state per walk, stalls while the result register is busy
  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // table, queue and a pending result held back until its last flag is known
  ffa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_op_i     (s_axis_tuser),
    .in_owner_i  (s_axis_tdata[15:0]),
    .in_size_i   (s_axis_tdata[32:16]),
    .in_addr_i   (s_axis_tdata[48:33]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_num_o   (out_num),
    .out_kind_o  (m_axis_tuser),
    .out_val_o   (out_val),
    .out_ovf_o   (out_ovf),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_ovf, out_val, out_num};

endmodule

// ===== hdl/ffa_sva.sv =====
// port-level checker for the allocator, bound to the top level
module ffa_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // one request in flight: no new request right after one is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken back to back");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // status answers are 0 or 1 and never flag overflow
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[32:17] == 16'h0) && !m_axis_tdata[33])
    else $error("bad status answer");

  // an overflow drop answers -1 and ends the request
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33] |->
      !m_axis_tuser && (m_axis_tdata[32:16] == 17'h1ffff) && m_axis_tlast)
    else $error("bad overflow answer");

endmodule

bind first_fit_allocator_with_pending_queue_top ffa_sva u_sva (.*);

// ===== test/tb_first_fit_allocator_with_pending_queue_top.sv =====
// self-checking testbench of the first-fit allocator with a queue of waiting requests
module tb_first_fit_allocator_with_pending_queue_top;

  localparam int CYCLE_LIMIT = 2000000;

  // one result as it leaves the block
  typedef struct packed {
    logic [15:0] num;
    logic        kind;
    logic [16:0] value;
    logic        ovf;
    logic        last;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;

  first_fit_allocator_with_pending_queue_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: a mirror of the region table and the waiting queue
  logic [16:0] mem_units;
  logic [15:0] reg_start [ffa_pkg::TABLE_DEPTH];
  logic [16:0] reg_len   [ffa_pkg::TABLE_DEPTH];
  logic [15:0] reg_own   [ffa_pkg::TABLE_DEPTH];
  int          reg_cnt;
  logic [16:0] wait_len  [ffa_pkg::QUEUE_DEPTH];
  logic [15:0] wait_own  [ffa_pkg::QUEUE_DEPTH];
  logic [15:0] wait_num  [ffa_pkg::QUEUE_DEPTH];
  int          wait_cnt;
  logic [15:0] req_ctr;

  answer_t pending_answers[$];
  answer_t step_out[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      answers_seen = 0;
  int      requests_sent = 0;
  int      long_stall = 0;
  int      owner_pool = 8;
  int      size_span = 64;
  int      ops_seen[4] = '{0, 0, 0, 0};
  bit      send_idle_on = 1'b1;
  bit      take_idle_on = 1'b1;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic void reg_insert(int pos, logic [15:0] st, logic [16:0] ln,
                                     logic [15:0] ow);
    for (int k = reg_cnt; k > pos; k--) begin
      reg_start[k] = reg_start[k-1];
      reg_len[k]   = reg_len[k-1];
      reg_own[k]   = reg_own[k-1];
    end
    reg_start[pos] = st;
    reg_len[pos]   = ln;
    reg_own[pos]   = ow;
    reg_cnt++;
  endfunction

  function automatic void reg_remove(int pos);
    for (int k = pos; k + 1 < reg_cnt; k++) begin
      reg_start[k] = reg_start[k+1];
      reg_len[k]   = reg_len[k+1];
      reg_own[k]   = reg_own[k+1];
    end
    reg_cnt--;
  endfunction

  function automatic void wait_remove(int pos);
    for (int k = pos; k + 1 < wait_cnt; k++) begin
      wait_len[k] = wait_len[k+1];
      wait_own[k] = wait_own[k+1];
      wait_num[k] = wait_num[k+1];
    end
    wait_cnt--;
  endfunction

  // first fit over the whole memory
  function automatic bit first_fit(logic [16:0] ln, output int pos, output int st);
    longint cur = 0;
    pos = 0;
    st = 0;
    if (reg_cnt >= ffa_pkg::TABLE_DEPTH) return 1'b0;
    for (int k = 0; k < reg_cnt; k++) begin
      if (longint'(reg_start[k]) - cur >= longint'(ln)) begin
        pos = k;
        st = int'(cur);
        return 1'b1;
      end
      cur = longint'(reg_start[k]) + longint'(reg_len[k]);
    end
    if (longint'(mem_units) - cur >= longint'(ln) && cur < 65536) begin
      pos = reg_cnt;
      st = int'(cur);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_answer(logic [15:0] num, logic kind, int value, logic ovf);
    answer_t a;
    a.num   = num;
    a.kind  = kind;
    a.value = value[16:0];
    a.ovf   = ovf;
    a.last  = 1'b0;
    step_out.insert(step_out.size(), a);
  endfunction

  // works out every result of one request and updates the mirror
  function automatic void predict_request(ffa_pkg::op_e op, logic [15:0] own,
                                          logic [16:0] sz, logic [15:0] addr);
    int  pos, st, k;
    bit  hit, removed;
    longint cur, nxt;
    answer_t a;
    step_out.delete();
    case (op)
      ffa_pkg::OP_ALLOC: begin
        if (reg_cnt == 0 && mem_units < sz) begin
          push_answer(req_ctr, 1'b0, -1, 1'b0);
        end else if (first_fit(sz, pos, st)) begin
          reg_insert(pos, st[15:0], sz, own);
          push_answer(req_ctr, 1'b0, st, 1'b0);
        end else if (wait_cnt < ffa_pkg::QUEUE_DEPTH) begin
          wait_len[wait_cnt] = sz;
          wait_own[wait_cnt] = own;
          wait_num[wait_cnt] = req_ctr;
          wait_cnt++;
          push_answer(req_ctr, 1'b0, -1, 1'b0);
        end else begin
          push_answer(req_ctr, 1'b0, -1, 1'b1);
        end
      end
      ffa_pkg::OP_FREE: begin
        cur = 0;
        hit = 1'b0;
        for (k = 0; k < reg_cnt; k++) begin
          if (reg_start[k] == addr) begin
            hit = (reg_own[k] == own);
            break;
          end
          cur = longint'(reg_start[k]) + longint'(reg_len[k]);
        end
        push_answer(req_ctr, 1'b1, hit ? 0 : 1, 1'b0);
        if (hit) begin
          pos = k;
          reg_remove(k);
          nxt = (pos < reg_cnt) ? longint'(reg_start[pos]) : longint'(mem_units);
          k = 0;
          // refill the freed gap in queue order
          while (k < wait_cnt) begin
            if (nxt - cur <= 0) break;
            if (longint'(wait_len[k]) <= nxt - cur && reg_cnt < ffa_pkg::TABLE_DEPTH) begin
              reg_insert(pos, cur[15:0], wait_len[k], wait_own[k]);
              push_answer(wait_num[k], 1'b0, int'(cur), 1'b0);
              cur += longint'(wait_len[k]);
              pos++;
              wait_remove(k);
            end else begin
              k++;
            end
          end
        end
      end
      ffa_pkg::OP_TERM: begin
        removed = 1'b0;
        k = 0;
        while (k < wait_cnt) begin
          if (wait_own[k] == own) wait_remove(k);
          else k++;
        end
        k = 0;
        while (k < reg_cnt) begin
          if (reg_own[k] == own) begin
            reg_remove(k);
            removed = 1'b1;
          end else begin
            k++;
          end
        end
        push_answer(req_ctr, 1'b1, removed ? 0 : 1, 1'b0);
        if (removed) begin
          k = 0;
          while (k < wait_cnt) begin
            if (first_fit(wait_len[k], pos, st)) begin
              reg_insert(pos, st[15:0], wait_len[k], wait_own[k]);
              push_answer(wait_num[k], 1'b0, st, 1'b0);
              wait_remove(k);
            end else begin
              k++;
            end
          end
        end
      end
      default: begin
        push_answer(req_ctr, 1'b1, 1, 1'b0);
      end
    endcase
    a = step_out.pop_back();
    a.last = 1'b1;
    step_out.insert(step_out.size(), a);
    foreach (step_out[i]) pending_answers.insert(pending_answers.size(), step_out[i]);
    req_ctr++;
  endfunction

  // sends one request, predicting it once it has been taken
  task automatic send_request(ffa_pkg::op_e op, logic [15:0] own, logic [16:0] sz,
                              logic [15:0] addr);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 3) : 0;
    repeat (gap) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {7'b0, addr, sz, own};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(op, own, sz, addr);
    ops_seen[op]++;
    requests_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // lets the block finish work that gives no result, then writes memory_size
  task automatic write_mem_size(logic [16:0] value);
    wait (pending_answers.size() == 0);
    repeat (3000) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mem_units = (value > ffa_pkg::MEM_MAX) ? ffa_pkg::MEM_MAX : value;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (long_stall) @(negedge clk_i);
        long_stall = 0;
      end
      gap = take_idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // checks each result against the oldest expectation
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result num %0d", m_axis_tdata[15:0]));
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tdata[15:0] !== want.num)
          report_mismatch($sformatf("request_number %0d, want %0d",
                                    m_axis_tdata[15:0], want.num));
        if (m_axis_tuser !== want.kind)
          report_mismatch($sformatf("answer_kind %0b, want %0b (num %0d)",
                                    m_axis_tuser, want.kind, want.num));
        if (m_axis_tdata[32:16] !== want.value)
          report_mismatch($sformatf("answer_value %0h, want %0h (num %0d)",
                                    m_axis_tdata[32:16], want.value, want.num));
        if (m_axis_tdata[33] !== want.ovf)
          report_mismatch($sformatf("queue_overflow %0b, want %0b (num %0d)",
                                    m_axis_tdata[33], want.ovf, want.num));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %0b, want %0b (num %0d)",
                                    m_axis_tlast, want.last, want.num));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_answers.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // random request drawn from a small owner pool so that frees and terminates hit
  task automatic send_random_request();
    int pick, k;
    logic [15:0] own, addr;
    logic [16:0] sz;
    pick = $urandom_range(0, 99);
    own  = 16'($urandom_range(0, owner_pool - 1));
    sz   = 17'($urandom_range(0, size_span));
    addr = 16'($urandom);
    if (pick < 3) begin
      own = 16'($urandom);
      sz  = 17'($urandom);
    end
    if (pick < 50) begin
      send_request(ffa_pkg::OP_ALLOC, own, sz, addr);
    end else if (pick < 85) begin
      // mostly a real region, sometimes with the wrong owner
      if (reg_cnt > 0 && pick < 80) begin
        k = $urandom_range(0, reg_cnt - 1);
        addr = reg_start[k];
        if (pick < 75) own = reg_own[k];
      end
      send_request(ffa_pkg::OP_FREE, own, sz, addr);
    end else if (pick < 97) begin
      send_request(ffa_pkg::OP_TERM, own, sz, addr);
    end else begin
      send_request(ffa_pkg::OP_NONE, own, sz, addr);
    end
  endtask

  task automatic test_directed_extremes();
    send_request(ffa_pkg::OP_ALLOC, 16'hFFFF, 17'h1FFFF, 16'hFFFF); // empty table, oversized
    send_request(ffa_pkg::OP_ALLOC, 16'h0000, 17'd0, 16'h0000);     // zero length at address 0
    send_request(ffa_pkg::OP_ALLOC, 16'h0001, 17'h10000, 16'h0);    // whole memory, placed after the zero-length region
    send_request(ffa_pkg::OP_ALLOC, 16'h0002, 17'd100, 16'h0);
    send_request(ffa_pkg::OP_ALLOC, 16'h0003, 17'd200, 16'h0);
    send_request(ffa_pkg::OP_FREE, 16'h0003, 17'd0, 16'd0);         // wrong owner
    send_request(ffa_pkg::OP_FREE, 16'h0002, 17'd0, 16'd5);         // no region there
    send_request(ffa_pkg::OP_FREE, 16'h0002, 17'd0, 16'd0);         // no hit, wrong owner
    send_request(ffa_pkg::OP_FREE, 16'h0000, 17'd0, 16'd0);
    send_request(ffa_pkg::OP_ALLOC, 16'h0004, 17'd50, 16'h0);
    send_request(ffa_pkg::OP_FREE, 16'h0003, 17'd0, 16'd100);       // no region at 100
    send_request(ffa_pkg::OP_TERM, 16'h0007, 17'd0, 16'd0);         // owner with nothing
    send_request(ffa_pkg::OP_TERM, 16'h0002, 17'd0, 16'd0);         // queued, no region
    send_request(ffa_pkg::OP_TERM, 16'h0004, 17'd0, 16'd0);
    send_request(ffa_pkg::OP_NONE, 16'hFFFF, 17'h1FFFF, 16'hFFFF);  // unused opcode
    send_request(ffa_pkg::OP_ALLOC, 16'h5555, 17'h0AAAA, 16'h5555);
    send_request(ffa_pkg::OP_ALLOC, 16'hAAAA, 17'h15555, 16'hAAAA);
    send_request(ffa_pkg::OP_TERM, 16'h0001, 17'd0, 16'd0);
    send_request(ffa_pkg::OP_TERM, 16'h5555, 17'd0, 16'd0);
    send_request(ffa_pkg::OP_TERM, 16'hAAAA, 17'd0, 16'd0);
  endtask

  // small memory so that the table and queue fill and overflow
  task automatic test_fill_and_overflow();
    write_mem_size(17'd40);
    for (int k = 0; k < 34; k++) send_request(ffa_pkg::OP_ALLOC, 16'(k % 4), 17'd1, 16'd0);
    for (int k = 0; k < 18; k++) send_request(ffa_pkg::OP_ALLOC, 16'd5, 17'd30, 16'd0);
    send_request(ffa_pkg::OP_TERM, 16'd0, 17'd0, 16'd0);
    send_request(ffa_pkg::OP_TERM, 16'd5, 17'd0, 16'd0);
    for (int k = 1; k < 4; k++) send_request(ffa_pkg::OP_TERM, 16'(k), 17'd0, 16'd0);
  endtask

  // receiver holds off while requests keep coming
  task automatic test_output_backpressure();
    long_stall = 400;
    for (int k = 0; k < 20; k++) send_random_request();
    // sender pauses until every result is back
    wait (pending_answers.size() == 0);
  endtask

  task automatic test_random_traffic(int count, int owners, int span);
    owner_pool = owners;
    size_span = span;
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 30) begin
        send_idle_on = 1'b0;
        take_idle_on = 1'b0;
      end else if (k % 60 == 45) begin
        send_idle_on = 1'b1;
        take_idle_on = 1'b1;
      end
      send_random_request();
    end
    send_idle_on = 1'b1;
    take_idle_on = 1'b1;
  endtask

  task automatic clear_owners(int owners);
    for (int k = 0; k < owners; k++) send_request(ffa_pkg::OP_TERM, 16'(k), 17'd0, 16'd0);
  endtask

  initial begin
    mem_units = ffa_pkg::MEM_MAX;
    reg_cnt = 0;
    wait_cnt = 0;
    req_ctr = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_extremes();
    test_fill_and_overflow();
    write_mem_size(17'd200);
    test_output_backpressure();
    test_random_traffic(50, 6, 60);
    clear_owners(8);
    write_mem_size(17'd0);        // only zero-length regions fit
    test_random_traffic(20, 3, 2);
    clear_owners(3);
    write_mem_size(17'h1FFFF);    // saturates to the full memory
    test_random_traffic(40, 8, 20000);
    write_mem_size(17'd1);
    test_random_traffic(25, 4, 2);
    clear_owners(4);
    write_mem_size(17'd512);
    test_random_traffic(35, 10, 100);
    wait (pending_answers.size() == 0);
    repeat (3000) @(negedge clk_i);
    $display("%0d requests (alloc %0d, free %0d, terminate %0d, other %0d), %0d results",
             requests_sent, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3], answers_seen);
    $display("covered full table and queue overflow, long output hold-off, memory sizes 0..max");
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
